// ----- src/pcs_pkg.sv -----
// Shared types and constants for the periodic cell step block.
// Used by the channel interfaces and by the top level; depends on nothing.
package pcs_pkg;

	// Q16.32 signed cell and gradient entries.
	typedef logic signed [47:0] fix_t;
	typedef logic [46:0] len_out_t;
	typedef logic [32:0] sine_t;

	localparam fix_t ONE_Q32 = 48'sh0001_0000_0000;

	// Register indexes of the configuration port (byte address 8*index).
	localparam logic [2:0] REG_STEP_SIZE = 3'd0;
	localparam logic [2:0] REG_REF_XX    = 3'd1;
	localparam logic [2:0] REG_REF_XY    = 3'd2;
	localparam logic [2:0] REG_REF_YX    = 3'd3;
	localparam logic [2:0] REG_REF_YY    = 3'd4;

	// Operation codes of a command word.
	localparam logic OP_STEP   = 1'b0;
	localparam logic OP_RELOAD = 1'b1;

	// Last iteration index of each iterative unit.
	localparam logic [1:0] MUL_LAST  = 2'd3;
	localparam logic [5:0] SQRT_LAST = 6'd48;
	localparam logic [6:0] DIV_LAST  = 7'd80;

endpackage

// ----- src/pcs_channels.sv -----
// Valid/ready channel interfaces for command and result words.
// Depends on pcs_pkg for the payload types.
interface pcs_cmd_if;
	logic          valid;
	logic          ready;
	logic          operation;
	pcs_pkg::fix_t grad_xx;
	pcs_pkg::fix_t grad_xy;
	pcs_pkg::fix_t grad_yx;
	pcs_pkg::fix_t grad_yy;
	modport source (output valid, operation, grad_xx, grad_xy, grad_yx, grad_yy, input ready);
	modport sink (input valid, operation, grad_xx, grad_xy, grad_yx, grad_yy, output ready);
endinterface

interface pcs_res_if;
	logic              valid;
	logic              ready;
	pcs_pkg::len_out_t length_a;
	pcs_pkg::len_out_t length_b;
	pcs_pkg::sine_t    skew_sine;
	logic              sheared;
	logic              degenerate;
	pcs_pkg::fix_t     unshear_xx;
	pcs_pkg::fix_t     unshear_xy;
	pcs_pkg::fix_t     unshear_yx;
	pcs_pkg::fix_t     unshear_yy;
	modport source (output valid, length_a, length_b, skew_sine, sheared, degenerate,
		unshear_xx, unshear_xy, unshear_yx, unshear_yy, input ready);
	modport sink (input valid, length_a, length_b, skew_sine, sheared, degenerate,
		unshear_xx, unshear_xy, unshear_yx, unshear_yy, output ready);
endinterface

// ----- src/periodic_cell_step_2d.sv -----
// Periodic 2-D cell update: H += (step_size*G)*H, then lengths, skew sine and unshear matrix.
// A step word issues 23 products, a reload word (which loads H from the reference registers)
// 11, plus up to 3 square roots and 8 divisions (fewer if degenerate); each runs on its
// shared unit and is written back once the unit is done. One word is in work at a time;
// a finished result waits in the output register while the next word is accepted.
// Reset (arst_n, asynchronous) sets H and the reference registers to the identity.
module periodic_cell_step_2d (
	input  logic          clk,
	input  logic          arst_n,
	pcs_cmd_if.sink       cmd,
	pcs_res_if.source     res,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);

	typedef enum logic [3:0] {
		S_IDLE, S_INC, S_UPD, S_SQ, S_ROOT, S_DET, S_NORM, S_PROD, S_DD, S_SINE, S_UNS, S_DONE
	} state_t;

	// Magnitude helpers.
	function automatic logic [47:0] mag48(input logic signed [47:0] v);
		mag48 = v[47] ? 48'(-v) : 48'(v);
	endfunction

	function automatic logic [32:0] mag_n(input logic signed [33:0] v);
		logic [33:0] t;
		t = v[33] ? 34'(-v) : 34'(v);
		return t[32:0];
	endfunction

	function automatic logic [35:0] mag36(input logic signed [35:0] v);
		mag36 = v[35] ? 36'(-v) : 36'(v);
	endfunction

	// Saturate a wide signed sum to 48 bits.
	function automatic pcs_pkg::fix_t sat48(input logic signed [65:0] v);
		if (v[65:47] == {19{v[65]}}) begin
			return v[47:0];
		end
		return v[65] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
	endfunction

	state_t state_q;
	logic [2:0] idx_q;
	logic go_q;

	logic [31:0] step_q;
	pcs_pkg::fix_t ref_q [4];
	pcs_pkg::fix_t g_q [4];
	pcs_pkg::fix_t h_q [4];
	pcs_pkg::fix_t inc_q [4];
	pcs_pkg::fix_t nh_q [4];
	logic signed [65:0] acc_q;
	logic [95:0] sqs_q [2];
	logic [48:0] len_q [2];
	logic signed [96:0] detp_q;
	logic signed [33:0] n_q [4];
	logic signed [35:0] dn_q, dot_q;
	logic [63:0] dd_q;
	logic [32:0] sine_q;
	pcs_pkg::fix_t uns_q [4];
	logic degen_q;

	// Multiplier unit: 48x48 magnitudes, one 24x24 partial product a cycle.
	logic mul_start, mul_busy_q;
	logic [1:0] mul_cnt_q;
	logic [47:0] mul_a, mul_b, mul_a_q, mul_b_q;
	logic [95:0] mul_p_q, pp_sh;
	logic [23:0] a_part, b_part;
	logic [47:0] pp;

	// Square root unit: 98-bit operand, two operand bits a cycle.
	logic sq_start, sq_busy_q;
	logic [5:0] sq_cnt_q;
	logic [97:0] sq_opnd, sq_op_q;
	logic [51:0] sq_rem_q, sq_rem_sh, sq_trial;
	logic [48:0] sq_root_q;

	// Divider unit: 81-bit numerator, 49-bit divisor, one quotient bit a cycle.
	logic dv_start, dv_busy_q;
	logic [6:0] dv_cnt_q;
	logic [80:0] dv_num, dv_num_q, dv_quo_q;
	logic [48:0] dv_den, dv_den_q;
	logic [49:0] dv_rem_q, dv_rem_sh;

	logic uses_mul, uses_sqrt, uses_div, unit_done;
	logic [1:0] pa_idx, pb_idx, un_idx;
	logic [32:0] dm;
	logic [35:0] dot_mag;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cmd.ready = (state_q == S_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			ref_q[0] <= pcs_pkg::ONE_Q32;
			ref_q[1] <= '0;
			ref_q[2] <= '0;
			ref_q[3] <= pcs_pkg::ONE_Q32;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				pcs_pkg::REG_STEP_SIZE: step_q <= pwdata[31:0];
				pcs_pkg::REG_REF_XX: ref_q[0] <= pwdata[47:0];
				pcs_pkg::REG_REF_XY: ref_q[1] <= pwdata[47:0];
				pcs_pkg::REG_REF_YX: ref_q[2] <= pwdata[47:0];
				pcs_pkg::REG_REF_YY: ref_q[3] <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[5:3])
			pcs_pkg::REG_STEP_SIZE: prdata = {32'b0, step_q};
			pcs_pkg::REG_REF_XX: prdata = {{16{ref_q[0][47]}}, ref_q[0]};
			pcs_pkg::REG_REF_XY: prdata = {{16{ref_q[1][47]}}, ref_q[1]};
			pcs_pkg::REG_REF_YX: prdata = {{16{ref_q[2][47]}}, ref_q[2]};
			pcs_pkg::REG_REF_YY: prdata = {{16{ref_q[3][47]}}, ref_q[3]};
			default: prdata = '0;
		endcase
	end

	// Operand pairs for the normalised products and the unshear numerators.
	always_comb begin
		case (idx_q[1:0])
			2'd0: begin pa_idx = 2'd0; pb_idx = 2'd3; un_idx = 2'd3; end
			2'd1: begin pa_idx = 2'd1; pb_idx = 2'd2; un_idx = 2'd1; end
			2'd2: begin pa_idx = 2'd0; pb_idx = 2'd1; un_idx = 2'd2; end
			default: begin pa_idx = 2'd2; pb_idx = 2'd3; un_idx = 2'd0; end
		endcase
	end

	assign dot_mag = mag36(dot_q);
	assign dm = (dot_mag > 36'h1_0000_0000) ? 33'h1_0000_0000 : dot_mag[32:0];

	// Operand selection for the shared units.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sq_opnd = '0;
		dv_num = '0;
		dv_den = '0;
		uses_mul = 1'b0;
		uses_sqrt = 1'b0;
		uses_div = 1'b0;
		case (state_q)
			S_INC: begin
				uses_mul = 1'b1;
				mul_a = {16'b0, step_q};
				mul_b = mag48(g_q[idx_q[1:0]]);
			end
			S_UPD: begin
				uses_mul = 1'b1;
				mul_a = mag48(inc_q[{idx_q[2], idx_q[0]}]);
				mul_b = mag48(h_q[{idx_q[0], idx_q[1]}]);
			end
			S_SQ: begin
				uses_mul = 1'b1;
				mul_a = mag48(h_q[{idx_q[0], idx_q[1]}]);
				mul_b = mul_a;
			end
			S_DET: begin
				uses_mul = 1'b1;
				mul_a = mag48(idx_q[0] ? h_q[1] : h_q[0]);
				mul_b = mag48(idx_q[0] ? h_q[2] : h_q[3]);
			end
			S_ROOT: begin
				uses_sqrt = 1'b1;
				sq_opnd = {2'b0, sqs_q[idx_q[0]]};
			end
			S_NORM: begin
				uses_div = 1'b1;
				dv_num = {1'b0, mag48(h_q[idx_q[1:0]]), 32'b0};
				dv_den = len_q[idx_q[0]];
			end
			S_PROD: begin
				uses_mul = 1'b1;
				mul_a = {15'b0, mag_n(n_q[pa_idx])};
				mul_b = {15'b0, mag_n(n_q[pb_idx])};
			end
			S_DD: begin
				uses_mul = 1'b1;
				mul_a = {15'b0, dm};
				mul_b = {15'b0, dm};
			end
			S_SINE: begin
				uses_sqrt = 1'b1;
				sq_opnd = {33'b0, 65'h1_0000_0000_0000_0000 - {1'b0, dd_q}};
			end
			S_UNS: begin
				uses_div = 1'b1;
				dv_num = {16'b0, mag_n(n_q[un_idx]), 32'b0};
				dv_den = {13'b0, mag36(dn_q)};
			end
			default: ;
		endcase
	end

	assign mul_start = uses_mul & ~go_q;
	assign sq_start  = uses_sqrt & ~go_q;
	assign dv_start  = uses_div & ~go_q;
	assign unit_done = go_q & ~mul_busy_q & ~sq_busy_q & ~dv_busy_q;

	// Multiplier datapath.
	assign a_part = mul_cnt_q[1] ? mul_a_q[47:24] : mul_a_q[23:0];
	assign b_part = mul_cnt_q[0] ? mul_b_q[47:24] : mul_b_q[23:0];
	assign pp = a_part * b_part;
	always_comb begin
		case (2'(mul_cnt_q[1]) + 2'(mul_cnt_q[0]))
			2'd0: pp_sh = {48'b0, pp};
			2'd1: pp_sh = {24'b0, pp, 24'b0};
			default: pp_sh = {pp, 48'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_cnt_q <= '0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			mul_p_q <= '0;
		end else if (mul_start) begin
			mul_busy_q <= 1'b1;
			mul_cnt_q <= '0;
			mul_a_q <= mul_a;
			mul_b_q <= mul_b;
			mul_p_q <= '0;
		end else if (mul_busy_q) begin
			mul_p_q <= mul_p_q + pp_sh;
			mul_cnt_q <= mul_cnt_q + 2'd1;
			if (mul_cnt_q == pcs_pkg::MUL_LAST) begin
				mul_busy_q <= 1'b0;
			end
		end
	end

	// Square root datapath: restoring digit recurrence.
	assign sq_rem_sh = {sq_rem_q[49:0], sq_op_q[97:96]};
	assign sq_trial = {1'b0, sq_root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q <= '0;
			sq_op_q <= '0;
			sq_rem_q <= '0;
			sq_root_q <= '0;
		end else if (sq_start) begin
			sq_busy_q <= 1'b1;
			sq_cnt_q <= '0;
			sq_op_q <= sq_opnd;
			sq_rem_q <= '0;
			sq_root_q <= '0;
		end else if (sq_busy_q) begin
			sq_op_q <= {sq_op_q[95:0], 2'b00};
			if (sq_rem_sh >= sq_trial) begin
				sq_rem_q <= sq_rem_sh - sq_trial;
				sq_root_q <= {sq_root_q[47:0], 1'b1};
			end else begin
				sq_rem_q <= sq_rem_sh;
				sq_root_q <= {sq_root_q[47:0], 1'b0};
			end
			sq_cnt_q <= sq_cnt_q + 6'd1;
			if (sq_cnt_q == pcs_pkg::SQRT_LAST) begin
				sq_busy_q <= 1'b0;
			end
		end
	end

	// Divider datapath: restoring division.
	assign dv_rem_sh = {dv_rem_q[48:0], dv_num_q[80]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q <= '0;
			dv_num_q <= '0;
			dv_den_q <= '0;
			dv_rem_q <= '0;
			dv_quo_q <= '0;
		end else if (dv_start) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q <= '0;
			dv_num_q <= dv_num;
			dv_den_q <= dv_den;
			dv_rem_q <= '0;
			dv_quo_q <= '0;
		end else if (dv_busy_q) begin
			dv_num_q <= {dv_num_q[79:0], 1'b0};
			if (dv_rem_sh >= {1'b0, dv_den_q}) begin
				dv_rem_q <= dv_rem_sh - {1'b0, dv_den_q};
				dv_quo_q <= {dv_quo_q[79:0], 1'b1};
			end else begin
				dv_rem_q <= dv_rem_sh;
				dv_quo_q <= {dv_quo_q[79:0], 1'b0};
			end
			dv_cnt_q <= dv_cnt_q + 7'd1;
			if (dv_cnt_q == pcs_pkg::DIV_LAST) begin
				dv_busy_q <= 1'b0;
			end
		end
	end

	// Write-back values derived from the finished unit.
	logic inc_neg, upd_neg, det_neg, prod_neg, uns_neg, uns_over;
	logic signed [47:0] inc_val;
	logic signed [65:0] upd_sp, upd_acc;
	logic signed [96:0] det_val;
	logic signed [35:0] prod_val;
	logic signed [33:0] norm_val;
	logic [47:0] uns_mag;
	pcs_pkg::fix_t uns_val;
	logic signed [35:0] dn_next;

	always_comb begin
		inc_neg = g_q[idx_q[1:0]][47];
		inc_val = inc_neg ? 48'(-$signed({1'b0, mul_p_q[78:32]})) : {1'b0, mul_p_q[78:32]};
		upd_neg = inc_q[{idx_q[2], idx_q[0]}][47] ^ h_q[{idx_q[0], idx_q[1]}][47];
		upd_sp = upd_neg ? -$signed({2'b0, mul_p_q[95:32]}) : $signed({2'b0, mul_p_q[95:32]});
		upd_acc = (idx_q[0] ? acc_q : 66'(h_q[idx_q[2:1]])) + upd_sp;
		det_neg = idx_q[0] ? (h_q[1][47] ^ h_q[2][47]) : (h_q[0][47] ^ h_q[3][47]);
		det_val = det_neg ? -$signed({1'b0, mul_p_q}) : $signed({1'b0, mul_p_q});
		prod_neg = n_q[pa_idx][33] ^ n_q[pb_idx][33];
		prod_val = prod_neg ? -$signed({1'b0, mul_p_q[66:32]}) : $signed({1'b0, mul_p_q[66:32]});
		dn_next = dn_q - prod_val;
		norm_val = h_q[idx_q[1:0]][47] ? 34'(-$signed({1'b0, dv_quo_q[32:0]}))
			: $signed({1'b0, dv_quo_q[32:0]});
		// A negated numerator is negative only when the entry itself is positive.
		if (un_idx == 2'd1 || un_idx == 2'd2) begin
			uns_neg = (n_q[un_idx] > 34'sd0) != dn_q[35];
		end else begin
			uns_neg = n_q[un_idx][33] != dn_q[35];
		end
		uns_over = uns_neg ? (dv_quo_q > {33'b0, 1'b1, 47'b0})
			: (dv_quo_q > {34'b0, {47{1'b1}}});
		uns_mag = uns_over ? (uns_neg ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : dv_quo_q[47:0];
		uns_val = uns_neg ? 48'(-uns_mag) : uns_mag;
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			go_q <= 1'b0;
			degen_q <= 1'b0;
			h_q[0] <= pcs_pkg::ONE_Q32;
			h_q[1] <= '0;
			h_q[2] <= '0;
			h_q[3] <= pcs_pkg::ONE_Q32;
			res.valid <= 1'b0;
		end else begin
			// The output register empties on a handshake unless a new word replaces it.
			if (res.valid && res.ready && state_q != S_DONE) begin
				res.valid <= 1'b0;
			end
			if (mul_start || sq_start || dv_start) begin
				go_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						g_q[0] <= cmd.grad_xx;
						g_q[1] <= cmd.grad_xy;
						g_q[2] <= cmd.grad_yx;
						g_q[3] <= cmd.grad_yy;
						degen_q <= 1'b0;
						idx_q <= '0;
						if (cmd.operation == pcs_pkg::OP_RELOAD) begin
							for (int k = 0; k < 4; k++) h_q[k] <= ref_q[k];
							state_q <= S_SQ;
						end else begin
							state_q <= S_INC;
						end
					end
				end
				S_INC: begin
					if (unit_done) begin
						go_q <= 1'b0;
						inc_q[idx_q[1:0]] <= inc_val;
						idx_q <= (idx_q == 3'd3) ? 3'd0 : idx_q + 3'd1;
						if (idx_q == 3'd3) state_q <= S_UPD;
					end
				end
				S_UPD: begin
					// Entry idx[2:1], term idx[0]; H is replaced once all four are ready.
					if (unit_done) begin
						go_q <= 1'b0;
						acc_q <= upd_acc;
						if (idx_q[0]) nh_q[idx_q[2:1]] <= sat48(upd_acc);
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int k = 0; k < 3; k++) h_q[k] <= nh_q[k];
							h_q[3] <= sat48(upd_acc);
							state_q <= S_SQ;
						end
					end
				end
				S_SQ: begin
					if (unit_done) begin
						go_q <= 1'b0;
						sqs_q[idx_q[1]] <= (idx_q[0] ? sqs_q[idx_q[1]] : 96'b0) + mul_p_q;
						idx_q <= (idx_q == 3'd3) ? 3'd0 : idx_q + 3'd1;
						if (idx_q == 3'd3) state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (unit_done) begin
						go_q <= 1'b0;
						len_q[idx_q[0]] <= sq_root_q;
						idx_q <= idx_q[0] ? 3'd0 : 3'd1;
						if (idx_q[0]) state_q <= S_DET;
					end
				end
				S_DET: begin
					if (unit_done) begin
						go_q <= 1'b0;
						detp_q <= det_val;
						idx_q <= idx_q[0] ? 3'd0 : 3'd1;
						if (idx_q[0]) begin
							if (detp_q == det_val || len_q[0] == '0 || len_q[1] == '0) begin
								degen_q <= 1'b1;
								state_q <= S_DONE;
							end else begin
								state_q <= S_NORM;
							end
						end
					end
				end
				S_NORM: begin
					if (unit_done) begin
						go_q <= 1'b0;
						n_q[idx_q[1:0]] <= norm_val;
						idx_q <= (idx_q == 3'd3) ? 3'd0 : idx_q + 3'd1;
						if (idx_q == 3'd3) state_q <= S_PROD;
					end
				end
				S_PROD: begin
					// Determinant first, then the dot product of the columns.
					if (unit_done) begin
						go_q <= 1'b0;
						case (idx_q[1:0])
							2'd0: dn_q <= prod_val;
							2'd1: dn_q <= dn_next;
							2'd2: dot_q <= prod_val;
							default: dot_q <= dot_q + prod_val;
						endcase
						if (idx_q == 3'd1 && dn_next == 36'sd0) begin
							degen_q <= 1'b1;
							idx_q <= '0;
							state_q <= S_DONE;
						end else begin
							idx_q <= (idx_q == 3'd3) ? 3'd0 : idx_q + 3'd1;
							if (idx_q == 3'd3) state_q <= S_DD;
						end
					end
				end
				S_DD: begin
					if (unit_done) begin
						go_q <= 1'b0;
						dd_q <= mul_p_q[63:0];
						if (mul_p_q[95:64] != '0) begin
							sine_q <= '0;
							state_q <= S_UNS;
						end else begin
							state_q <= S_SINE;
						end
					end
				end
				S_SINE: begin
					if (unit_done) begin
						go_q <= 1'b0;
						sine_q <= sq_root_q[32:0];
						state_q <= S_UNS;
					end
				end
				S_UNS: begin
					if (unit_done) begin
						go_q <= 1'b0;
						uns_q[idx_q[1:0]] <= uns_val;
						idx_q <= (idx_q == 3'd3) ? 3'd0 : idx_q + 3'd1;
						if (idx_q == 3'd3) state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hand the word over once the output register is free.
					if (!res.valid || res.ready) begin
						res.valid <= 1'b1;
						res.degenerate <= degen_q;
						if (degen_q) begin
							res.length_a <= '0;
							res.length_b <= '0;
							res.skew_sine <= '0;
							res.sheared <= 1'b0;
							res.unshear_xx <= '0;
							res.unshear_xy <= '0;
							res.unshear_yx <= '0;
							res.unshear_yy <= '0;
						end else begin
							res.length_a <= (len_q[0][48:47] != 2'b0) ? {47{1'b1}} : len_q[0][46:0];
							res.length_b <= (len_q[1][48:47] != 2'b0) ? {47{1'b1}} : len_q[1][46:0];
							res.skew_sine <= sine_q;
							res.sheared <= (h_q[1] != '0) || (h_q[2] != '0);
							res.unshear_xx <= uns_q[0];
							res.unshear_xy <= uns_q[1];
							res.unshear_yx <= uns_q[2];
							res.unshear_yy <= uns_q[3];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
